// ===== sv/dtq_pkg.sv =====
package dtq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int RES_MS     = 10;

    localparam int FUNC_W  = 2;
    localparam int ID_W    = 4;
    localparam int DELAY_W = 32;
    localparam int TAG_W   = 32;
    localparam int ADV_W   = 16;
    localparam int ST_W    = 3;
    localparam int TICK_W  = 64;

    // divide by the resolution through a reciprocal multiply, exact for every delay
    localparam int RES_SHIFT = $clog2(RES_MS);
    localparam int MAGIC_W   = DELAY_W + 1;
    localparam int PROD_W    = MAGIC_W + DELAY_W;
    localparam int QUO_SHIFT = DELAY_W + RES_SHIFT;
    localparam logic [MAGIC_W-1:0] RES_MAGIC =
        MAGIC_W'(((65'd1 << QUO_SHIFT) / RES_MS) + 65'd1);

    localparam logic [FUNC_W-1:0] FN_START   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_STOP    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_ADVANCE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE    = 2'd3;

    localparam logic [ST_W-1:0] ST_ACCEPT  = 3'd0;
    localparam logic [ST_W-1:0] ST_FIRED   = 3'd1;
    localparam logic [ST_W-1:0] ST_NONE    = 3'd2;
    localparam logic [ST_W-1:0] ST_RUNNING = 3'd3;
    localparam logic [ST_W-1:0] ST_IDLE    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay_ms;
        logic [TAG_W-1:0]   tag;
        logic [ADV_W-1:0]   advance;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  fired_id;
        logic [TAG_W-1:0] fired_tag;
        logic             last;
    } rsp_t;

    // broadcast to every cell: arm or disarm the cell whose id matches
    typedef struct packed {
        logic              arm;
        logic              disarm;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } cell_ctl_t;

    // best due timer found so far by a sweep
    typedef struct packed {
        logic              found;
        logic [TICK_W-1:0] deadline;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
    } tok_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMD,
        S_SWEEP,
        S_DECIDE
    } state_t;

endpackage

// ===== sv/deadline_timer_queue_core.sv =====
// Sixteen one-shot timers in a row of cells, one cell per timer id, plus a
// 64-bit tick count starting at zero. A start or stop request passes through
// capture, a reciprocal multiply for the millisecond-to-tick division, then
// arm or disarm, which waits until the output register is free. An advance
// request sends a search token down the cell row, one cell per clock, to find
// the earliest due timer; an advance that fires k timers takes (k + 1) passes,
// as the last fire is only marked once a further pass finds nothing due. A
// new request is taken only once the previous one has finished, while its
// final result may still sit in the output register.
module deadline_timer_queue_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dtq_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dtq_pkg::rsp_t rsp_data
);

    dtq_pkg::state_t state_reg;
    dtq_pkg::state_t state_next;

    dtq_pkg::req_t   req_reg;
    logic [dtq_pkg::TICK_W-1:0] now_reg;
    logic [dtq_pkg::TICK_W-1:0] now_next;
    logic [dtq_pkg::PROD_W-1:0] prod_reg;
    logic [dtq_pkg::DELAY_W-1:0] quot;
    dtq_pkg::tok_t   res_reg;
    dtq_pkg::rsp_t   pend_reg;
    dtq_pkg::rsp_t   pend_next;
    logic            pend_valid_reg;
    logic            pend_valid_next;
    dtq_pkg::rsp_t   rsp_reg;
    dtq_pkg::rsp_t   rsp_next;
    logic            rsp_valid_reg;
    logic            rsp_load;
    logic            inject_reg;
    logic            inject_next;
    dtq_pkg::cell_ctl_t ctl;

    logic            accept;
    logic            rsp_free;
    logic            in_range;
    logic            running;
    logic            decide_go;

    logic [dtq_pkg::NUM_TIMERS:0]   tok_vld;
    dtq_pkg::tok_t                  tok [dtq_pkg::NUM_TIMERS+1];
    logic [dtq_pkg::NUM_TIMERS-1:0] armed;

    assign req_ready = (state_reg == dtq_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign quot      = dtq_pkg::DELAY_W'(prod_reg >> dtq_pkg::QUO_SHIFT);
    assign in_range  = (int'(req_reg.timer_id) < dtq_pkg::NUM_TIMERS);
    assign running   = armed[req_reg.timer_id];
    // the output is needed when a pending fire is released or nothing was due
    assign decide_go = rsp_free || !(pend_valid_reg || !res_reg.found);

    // cell row
    assign tok_vld[0] = inject_reg;
    assign tok[0]     = '0;

    for (genvar i = 0; i < dtq_pkg::NUM_TIMERS; i++)
    begin : g_cell
        dtq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_id     (dtq_pkg::ID_W'(i)),
            .now         (now_reg),
            .ctl         (ctl),
            .tok_vld_in  (tok_vld[i]),
            .tok_in      (tok[i]),
            .tok_vld_out (tok_vld[i+1]),
            .tok_out     (tok[i+1]),
            .armed       (armed[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_data.func == dtq_pkg::FN_ADVANCE)
                                 ? dtq_pkg::S_SWEEP : dtq_pkg::S_MUL;
                end
            end
            dtq_pkg::S_MUL:
            begin
                state_next = dtq_pkg::S_CMD;
            end
            dtq_pkg::S_CMD:
            begin
                if (rsp_free)
                begin
                    state_next = dtq_pkg::S_IDLE;
                end
            end
            dtq_pkg::S_SWEEP:
            begin
                if (tok_vld[dtq_pkg::NUM_TIMERS])
                begin
                    state_next = dtq_pkg::S_DECIDE;
                end
            end
            dtq_pkg::S_DECIDE:
            begin
                if (decide_go)
                begin
                    state_next = res_reg.found ? dtq_pkg::S_SWEEP : dtq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dtq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        now_next        = now_reg;
        inject_next     = 1'b0;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rsp_load        = 1'b0;
        rsp_next        = rsp_reg;
        ctl             = '0;
        unique case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (accept && (req_data.func == dtq_pkg::FN_ADVANCE))
                begin
                    now_next    = now_reg + dtq_pkg::TICK_W'(req_data.advance);
                    inject_next = 1'b1;
                end
            end
            dtq_pkg::S_MUL:
            begin
            end
            dtq_pkg::S_CMD:
            begin
                if (rsp_free)
                begin
                    rsp_load           = 1'b1;
                    rsp_next.fired_id  = req_reg.timer_id;
                    rsp_next.fired_tag = '0;
                    rsp_next.last      = 1'b1;
                    ctl.id             = req_reg.timer_id;
                    ctl.deadline       = now_reg + dtq_pkg::TICK_W'(quot);
                    ctl.tag            = req_reg.tag;
                    unique case (req_reg.func)
                        dtq_pkg::FN_START:
                        begin
                            if (!in_range)
                            begin
                                rsp_next.status = dtq_pkg::ST_IDLE;
                            end
                            else if (running)
                            begin
                                rsp_next.status = dtq_pkg::ST_RUNNING;
                            end
                            else
                            begin
                                ctl.arm         = 1'b1;
                                rsp_next.status = dtq_pkg::ST_ACCEPT;
                            end
                        end
                        dtq_pkg::FN_STOP:
                        begin
                            if (in_range && running)
                            begin
                                ctl.disarm      = 1'b1;
                                rsp_next.status = dtq_pkg::ST_ACCEPT;
                            end
                            else
                            begin
                                rsp_next.status = dtq_pkg::ST_IDLE;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = dtq_pkg::ST_NONE;
                        end
                    endcase
                end
            end
            dtq_pkg::S_SWEEP:
            begin
            end
            dtq_pkg::S_DECIDE:
            begin
                if (decide_go)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_load      = 1'b1;
                        rsp_next      = pend_reg;
                        rsp_next.last = !res_reg.found;
                    end
                    else if (!res_reg.found)
                    begin
                        rsp_load           = 1'b1;
                        rsp_next.status    = dtq_pkg::ST_NONE;
                        rsp_next.fired_id  = '0;
                        rsp_next.fired_tag = '0;
                        rsp_next.last      = 1'b1;
                    end
                    if (res_reg.found)
                    begin
                        pend_next.status    = dtq_pkg::ST_FIRED;
                        pend_next.fired_id  = res_reg.id;
                        pend_next.fired_tag = res_reg.tag;
                        pend_next.last      = 1'b0;
                        pend_valid_next     = 1'b1;
                        ctl.disarm          = 1'b1;
                        ctl.id              = res_reg.id;
                        inject_next         = 1'b1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dtq_pkg::S_IDLE;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            inject_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            inject_reg     <= inject_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_data;
        end
        prod_reg <= dtq_pkg::PROD_W'(req_reg.delay_ms) * dtq_pkg::PROD_W'(dtq_pkg::RES_MAGIC);
        if (tok_vld[dtq_pkg::NUM_TIMERS])
        begin
            res_reg <= tok[dtq_pkg::NUM_TIMERS];
        end
        pend_reg <= pend_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // only one search token travels the row at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one search token in the cell row");

    a_tail_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        tok_vld[dtq_pkg::NUM_TIMERS] |-> (state_reg == dtq_pkg::S_SWEEP))
        else $error("search token left the row outside a sweep");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::S_IDLE) |-> !pend_valid_reg)
        else $error("fire result left pending after advance request");

    a_winner_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::S_DECIDE && res_reg.found) |-> armed[res_reg.id])
        else $error("sweep picked a timer that is not armed");

    a_disarm_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::S_DECIDE && res_reg.found && decide_go)
        |=> !armed[$past(res_reg.id)])
        else $error("fired timer still armed");

endmodule

// ===== sv/dtq_cell.sv =====
module dtq_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dtq_pkg::ID_W-1:0]  cell_id,
    input  logic [dtq_pkg::TICK_W-1:0] now,
    input  dtq_pkg::cell_ctl_t        ctl,
    input  logic                      tok_vld_in,
    input  dtq_pkg::tok_t             tok_in,
    output logic                      tok_vld_out,
    output dtq_pkg::tok_t             tok_out,
    output logic                      armed
);

    logic                       armed_reg;
    logic                       armed_next;
    logic [dtq_pkg::TICK_W-1:0] deadline_reg;
    logic [dtq_pkg::TAG_W-1:0]  tag_reg;
    logic                       tok_vld_reg;
    dtq_pkg::tok_t              tok_reg;
    dtq_pkg::tok_t              tok_next;
    logic                       hit;
    logic                       take;

    assign hit = (ctl.id == cell_id);

    // lower ids sit earlier in the chain, so a strict compare keeps them on ties
    assign take = armed_reg && (deadline_reg <= now)
                  && (!tok_in.found || (deadline_reg < tok_in.deadline));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.deadline = deadline_reg;
            tok_next.id       = cell_id;
            tok_next.tag      = tag_reg;
        end
    end

    always_comb
    begin
        armed_next = armed_reg;
        if (ctl.arm && hit)
        begin
            armed_next = 1'b1;
        end
        else if (ctl.disarm && hit)
        begin
            armed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            armed_reg   <= armed_next;
            tok_vld_reg <= tok_vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.arm && hit)
        begin
            deadline_reg <= ctl.deadline;
            tag_reg      <= ctl.tag;
        end
        tok_reg <= tok_next;
    end

    assign tok_vld_out = tok_vld_reg;
    assign tok_out     = tok_reg;
    assign armed       = armed_reg;

endmodule

// ===== test/deadline_timer_queue_core_test.sv =====
module deadline_timer_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    localparam int TOTAL_REQUESTS = 330;
    localparam int QUIET_FROM     = 270;
    localparam int STALL_LIMIT    = 3000;

    // tracks the timer set and holds the results still owed by the block
    class timer_scoreboard;
        logic [TICK_W-1:0] now_ticks;
        logic [TICK_W-1:0] deadline [NUM_TIMERS];
        logic [TAG_W-1:0]  tag_store [NUM_TIMERS];
        bit                armed [NUM_TIMERS];
        rsp_t              owed_results [$];
        int unsigned       mismatches;

        function new();
            now_ticks = '0;
            foreach (armed[i])
            begin
                armed[i]     = 1'b0;
                deadline[i]  = '0;
                tag_store[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void owe(logic [ST_W-1:0] st, logic [ID_W-1:0] id, logic [TAG_W-1:0] tg,
                          logic lst);
            rsp_t r;
            r.status    = st;
            r.fired_id  = id;
            r.fired_tag = tg;
            r.last      = lst;
            owed_results.push_back(r);
        endfunction

        // random slot that is armed or idle as asked, any slot if there is none
        function int random_slot(bit want_armed);
            int cand [$];
            foreach (armed[i])
                if (armed[i] == want_armed)
                    cand.push_back(i);
            if (cand.size() == 0)
                return $urandom_range(0, NUM_TIMERS - 1);
            return cand[$urandom_range(0, cand.size() - 1)];
        endfunction

        function void note_request(req_t r);
            int id;
            int best;
            int fired;
            id    = int'(r.timer_id);
            fired = 0;
            case (r.func)
                FN_START:
                begin
                    if (armed[id])
                        owe(ST_RUNNING, r.timer_id, '0, 1'b1);
                    else
                    begin
                        armed[id]     = 1'b1;
                        tag_store[id] = r.tag;
                        deadline[id]  = now_ticks + (TICK_W'(r.delay_ms) / TICK_W'(RES_MS));
                        owe(ST_ACCEPT, r.timer_id, '0, 1'b1);
                    end
                end
                FN_STOP:
                begin
                    if (!armed[id])
                        owe(ST_IDLE, r.timer_id, '0, 1'b1);
                    else
                    begin
                        armed[id] = 1'b0;
                        owe(ST_ACCEPT, r.timer_id, '0, 1'b1);
                    end
                end
                FN_ADVANCE:
                begin
                    now_ticks = now_ticks + TICK_W'(r.advance);
                    // earliest deadline first, lowest id on ties
                    while (1)
                    begin
                        best = -1;
                        for (int i = 0; i < NUM_TIMERS; i++)
                            if (armed[i] && deadline[i] <= now_ticks &&
                                (best < 0 || deadline[i] < deadline[best]))
                                best = i;
                        if (best < 0)
                            break;
                        armed[best] = 1'b0;
                        owe(ST_FIRED, ID_W'(best), tag_store[best], 1'b0);
                        fired++;
                    end
                    if (fired == 0)
                        owe(ST_NONE, '0, '0, 1'b1);
                    else
                        owed_results[owed_results.size() - 1].last = 1'b1;
                end
                default:
                    owe(ST_NONE, r.timer_id, '0, 1'b1);
            endcase
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (owed_results.size() == 0)
                report($sformatf("response with nothing owed: status %0d id %0d tag %h last %b",
                                 got.status, got.fired_id, got.fired_tag, got.last));
            else
            begin
                want = owed_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, wanted %0d", got.status, want.status));
                if (got.fired_id !== want.fired_id)
                    report($sformatf("fired_id %0d, wanted %0d", got.fired_id, want.fired_id));
                if (got.fired_tag !== want.fired_tag)
                    report($sformatf("fired_tag %h, wanted %h", got.fired_tag, want.fired_tag));
                if (got.last !== want.last)
                    report($sformatf("last %b, wanted %b", got.last, want.last));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_data;

    timer_scoreboard sb;
    bit              quiet;
    int              gap_pct;
    int              sent;
    int              stall_cycles = 0;

    deadline_timer_queue_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp_data);

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // result side: ready stretches broken by stall bursts, ready throughout once quiet
    initial
    begin
        rsp_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            rsp_ready <= 1'b1;
            if (quiet)
                @(negedge clk);
            else
            begin
                repeat ($urandom_range(1, 40)) @(negedge clk);
                if ($urandom_range(0, 1) == 1)
                begin
                    rsp_ready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(negedge clk);
                end
            end
        end
    end

    function automatic req_t make_req(logic [FUNC_W-1:0] fn, int id, logic [DELAY_W-1:0] dly,
                                      logic [TAG_W-1:0] tg, logic [ADV_W-1:0] adv);
        req_t r;
        r.func     = fn;
        r.timer_id = ID_W'(id);
        r.delay_ms = dly;
        r.tag      = tg;
        r.advance  = adv;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   roll;
        r    = make_req(FUNC_W'($urandom), $urandom, $urandom, $urandom, ADV_W'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 42)
        begin
            r.func = FN_START;
            if ($urandom_range(0, 3) != 0)
                r.timer_id = ID_W'(sb.random_slot(1'b0));
            case ($urandom_range(0, 9))
                0: ;
                1, 2: r.delay_ms = $urandom_range(0, 65535);
                default: r.delay_ms = $urandom_range(0, 3000);
            endcase
        end
        else if (roll < 58)
        begin
            r.func = FN_STOP;
            if ($urandom_range(0, 3) != 0)
                r.timer_id = ID_W'(sb.random_slot(1'b1));
        end
        else if (roll < 95)
        begin
            r.func = FN_ADVANCE;
            case ($urandom_range(0, 24))
                0, 1: ;
                2, 3, 4: r.advance = ADV_W'($urandom_range(0, 1000));
                default: r.advance = ADV_W'($urandom_range(0, 60));
            endcase
        end
        else
            r.func = FN_NONE;
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send(req_t r);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.owed_results.size() != 0);
    endtask

    // arm every slot, then one long advance fires them all
    task automatic arm_all_and_fire();
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (sb.armed[i])
                send(make_req(FN_STOP, i, $urandom, $urandom, ADV_W'($urandom)));
            send(make_req(FN_START, i, $urandom_range(0, 5000), $urandom, ADV_W'($urandom)));
        end
        send(make_req(FN_ADVANCE, $urandom, $urandom, $urandom, 16'hFFFF));
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        quiet        = 1'b0;
        gap_pct      = 30;
        sent         = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        send(make_req(FN_STOP, 0, '0, '0, '0));
        send(make_req(FN_START, 0, '0, '0, '0));
        send(make_req(FN_START, 0, '1, '1, '1));
        // deadline equal to the current time fires at once
        send(make_req(FN_ADVANCE, 0, '1, '1, 16'd0));
        send(make_req(FN_ADVANCE, 15, '0, '0, 16'd0));
        send(make_req(FN_START, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
        send(make_req(FN_START, 7, 32'd9, 32'hA5A5_5A5A, '0));
        send(make_req(FN_START, 9, 32'd10, 32'h0000_0009, '0));
        send(make_req(FN_START, 3, 32'd19, 32'h3333_3333, '0));
        send(make_req(FN_START, 12, 32'd25, 32'hC0C0_C0C0, '0));
        send(make_req(FN_STOP, 12, '0, '0, '0));
        send(make_req(FN_STOP, 12, '1, '1, '1));
        send(make_req(FN_NONE, 6, '1, '1, '1));
        send(make_req(FN_NONE, 0, '0, '0, '0));
        // zero-tick timer first, then the tie at one tick in id order
        send(make_req(FN_ADVANCE, 0, '0, '0, 16'd1));
        send(make_req(FN_ADVANCE, 0, '0, '0, 16'hFFFF));
        send(make_req(FN_STOP, 15, '0, '0, '0));
        wait_for_results();
        arm_all_and_fire();
        wait_for_results();

        while (sent < TOTAL_REQUESTS)
        begin
            if (sent >= QUIET_FROM)
                quiet = 1'b1;
            if ($urandom_range(0, 39) == 0)
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 25;
                    default: gap_pct = 60;
                endcase
            case ($urandom_range(0, 99))
                0, 1: arm_all_and_fire();
                2, 3: wait_for_results();
                default: send(random_request());
            endcase
        end

        wait_for_results();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dtq_pkg.sv
sv/dtq_cell.sv
sv/deadline_timer_queue_core.sv
test/deadline_timer_queue_core_test.sv
